>>> rtl/core/voc_container_length_scanner_unit_assert.svh
// Assertion macros used by the scanner checker.
`ifndef VOC_CONTAINER_LENGTH_SCANNER_UNIT_ASSERT_SVH
`define VOC_CONTAINER_LENGTH_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define VCLS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scanner assertion failed");

// Next-cycle implication, disabled while in reset.
`define VCLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scanner assertion failed");

// Next-cycle implication that also covers the reset cycles.
`define VCLS_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scanner assertion failed");

`endif

>>> rtl/core/vcls_pkg.sv
`timescale 1ns / 1ps

package vcls_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_payload_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] file_length;
  } out_payload_t;

  typedef struct packed {
    logic [31:0] window_length;
  } cfg_payload_t;

  localparam int unsigned MAGIC_LEN = 20;
  localparam int unsigned HDR_LEN   = 4;

  localparam logic [31:0] WINDOW_RESET = 32'h1000_0000;

  localparam logic [7:0] BLK_TYPE_END  = 8'h00;
  localparam logic [7:0] BLK_TYPE_MAX  = 8'h0A;
  localparam logic [7:0] BLK_TYPE_EXT1 = 8'h08;
  localparam logic [7:0] BLK_TYPE_EXT2 = 8'h09;

  function automatic logic [7:0] magic_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h43;
      5'd1:    b = 8'h72;
      5'd2:    b = 8'h65;
      5'd3:    b = 8'h61;
      5'd4:    b = 8'h74;
      5'd5:    b = 8'h69;
      5'd6:    b = 8'h76;
      5'd7:    b = 8'h65;
      5'd8:    b = 8'h20;
      5'd9:    b = 8'h56;
      5'd10:   b = 8'h6F;
      5'd11:   b = 8'h69;
      5'd12:   b = 8'h63;
      5'd13:   b = 8'h65;
      5'd14:   b = 8'h20;
      5'd15:   b = 8'h46;
      5'd16:   b = 8'h69;
      5'd17:   b = 8'h6C;
      5'd18:   b = 8'h65;
      5'd19:   b = 8'h1A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/vcls_stream_if.sv
`timescale 1ns / 1ps

interface vcls_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/core/voc_container_length_scanner_unit.sv
`timescale 1ns / 1ps
// channel  | dir | payload                        | handshake
// in_chan  | in  | data_byte[7:0], last_byte      | valid/ready
// out_chan | out | accepted, file_length[31:0]    | valid/ready
// cfg_chan | in  | window_length[31:0]            | valid/ready, ready always high
// One byte per cycle unless a held result blocks; a result is registered in out_pl_r.
// The per-byte parser state update is one combinational pass behind the input register.
// rst_n is synchronous, active low; window_length returns to 0x10000000.
// A byte that yields no result moves on even while out_chan is stalled.
// A byte that yields a result waits only while an unclaimed result holds out_chan.

module voc_container_length_scanner_unit
  import vcls_pkg::*;
#(
  parameter int MAX_BLOCKS         = 2000000,
  parameter int TAIL_LIMIT         = 16,
  parameter int FIRST_BLOCK_OFFSET = 26
) (
  input  logic          clk,
  input  logic          rst_n,
  vcls_stream_if.sink   in_chan,
  vcls_stream_if.source out_chan,
  vcls_stream_if.sink   cfg_chan
);

  localparam logic [2:0] PH_MAGIC   = 3'd0;
  localparam logic [2:0] PH_GAP     = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_TAIL    = 3'd4;

  localparam logic [20:0] MAX_BLK  = 21'(MAX_BLOCKS);
  localparam logic [4:0]  TAIL_LIM = 5'(TAIL_LIMIT);
  localparam logic [32:0] FBO      = 33'(FIRST_BLOCK_OFFSET);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_go;
  logic        in_fire;

  logic [31:0] win_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [7:0]  btype_r, btype_nxt;
  logic [23:0] size_r, size_nxt;
  logic [23:0] skip_r, skip_nxt;
  logic [20:0] blocks_r, blocks_nxt;
  logic [4:0]  tail_r, tail_nxt;
  logic        decided_r, decided_nxt;

  logic        fin;
  logic        fin_ok;
  logic [31:0] fin_len;

  logic [32:0] pos33, win33, pos_p1;

  logic         out_valid_r;
  out_payload_t out_pl_r;

  assign in_fire = in_chan.valid && in_chan.ready;
  assign s1_go   = s1_valid_r && (!fin || !out_valid_r || out_chan.ready);

  assign in_chan.ready    = !s1_valid_r || s1_go;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_pl_r;
  assign cfg_chan.ready   = 1'b1;

  assign pos33  = {1'b0, pos_r};
  assign win33  = {1'b0, win_r};
  assign pos_p1 = pos33 + 33'd1;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    btype_nxt   = btype_r;
    size_nxt    = size_r;
    skip_nxt    = skip_r;
    blocks_nxt  = blocks_r;
    tail_nxt    = tail_r;
    fin         = 1'b0;
    fin_ok      = 1'b0;
    fin_len     = '0;

    if (!decided_r) begin
      case (phase_r)
        PH_MAGIC: begin
          if ((pos_r >= 32'(MAGIC_LEN)) || (magic_byte(pos_r[4:0]) != s1_byte_r)) begin
            fin = 1'b1;
          end else if (pos_r == 32'(MAGIC_LEN - 1)) begin
            phase_nxt = (FIRST_BLOCK_OFFSET > MAGIC_LEN) ? PH_GAP : PH_HEADER;
          end
        end
        PH_GAP: begin
          if (pos_p1 >= FBO) begin
            phase_nxt = PH_HEADER;
            skip_nxt  = '0;
          end
        end
        PH_HEADER: begin
          case (skip_r[1:0])
            2'd0: begin
              if ((pos33 + 33'(HDR_LEN) > win33) || (blocks_r >= MAX_BLK)) begin
                fin = 1'b1;
              end else begin
                btype_nxt = s1_byte_r;
                size_nxt  = '0;
                if (((s1_byte_r == BLK_TYPE_END) || (s1_byte_r > BLK_TYPE_MAX))
                    && (blocks_r == '0)) begin
                  fin = 1'b1;
                end else if (s1_byte_r > BLK_TYPE_MAX) begin
                  // early terminator: this type byte is the first tail byte
                  tail_nxt = '0;
                  if ((TAIL_LIMIT == 0) || (pos33 >= win33)) begin
                    fin     = 1'b1;
                    fin_ok  = 1'b1;
                    fin_len = pos_r;
                  end else begin
                    phase_nxt = PH_TAIL;
                    tail_nxt  = 5'd1;
                    if ((5'd1 >= TAIL_LIM) || (pos_p1 >= win33)) begin
                      fin     = 1'b1;
                      fin_ok  = 1'b1;
                      fin_len = pos_p1[31:0];
                    end
                  end
                end else begin
                  skip_nxt = 24'd1;
                end
              end
            end
            2'd1: begin
              if (btype_r != BLK_TYPE_END) size_nxt[7:0] = size_r[7:0] | s1_byte_r;
              skip_nxt = 24'd2;
            end
            2'd2: begin
              if (btype_r != BLK_TYPE_END) size_nxt[15:8] = size_r[15:8] | s1_byte_r;
              skip_nxt = 24'd3;
            end
            default: begin
              if ((btype_r == BLK_TYPE_EXT1) || (btype_r == BLK_TYPE_EXT2)) begin
                size_nxt[23:16] = size_r[23:16] | s1_byte_r;
              end
              skip_nxt = '0;
              if (btype_r == BLK_TYPE_END) begin
                tail_nxt = '0;
                if ((TAIL_LIMIT == 0) || (pos_p1 >= win33)) begin
                  fin     = 1'b1;
                  fin_ok  = 1'b1;
                  fin_len = pos_p1[31:0];
                end else begin
                  phase_nxt = PH_TAIL;
                end
              end else if ((size_nxt == '0) || (pos_p1 + {9'd0, size_nxt} > win33)) begin
                fin = 1'b1;
              end else begin
                skip_nxt   = size_nxt;
                phase_nxt  = PH_PAYLOAD;
                blocks_nxt = blocks_r + 21'd1;
              end
            end
          endcase
        end
        PH_PAYLOAD: begin
          if (skip_r != '0) skip_nxt = skip_r - 24'd1;
          if ((skip_r == '0) || (skip_r == 24'd1)) begin
            phase_nxt = PH_HEADER;
            size_nxt  = '0;
          end
        end
        PH_TAIL: begin
          if (s1_byte_r == 8'h00) begin
            fin     = 1'b1;
            fin_ok  = 1'b1;
            fin_len = pos_r;
          end else begin
            tail_nxt = tail_r + 5'd1;
            if ((tail_nxt >= TAIL_LIM) || (pos_p1 >= win33)) begin
              fin     = 1'b1;
              fin_ok  = 1'b1;
              fin_len = pos_p1[31:0];
            end
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase

      if (s1_last_r && !fin) begin
        fin = 1'b1;
        if (phase_nxt == PH_TAIL) begin
          fin_ok  = 1'b1;
          fin_len = pos_p1[31:0];
        end else if ((phase_nxt == PH_HEADER) && (btype_nxt == BLK_TYPE_END)
                     && (skip_nxt != '0)) begin
          // stream cut inside a terminator header: count the full header
          fin_ok  = 1'b1;
          fin_len = pos_r + 32'(HDR_LEN + 1) - {8'd0, skip_nxt};
        end
      end
    end

    decided_nxt = decided_r | fin;
    if (pos_r != '1) pos_nxt = pos_r + 32'd1;

    if (s1_last_r) begin
      phase_nxt   = PH_MAGIC;
      pos_nxt     = '0;
      btype_nxt   = '0;
      size_nxt    = '0;
      skip_nxt    = '0;
      blocks_nxt  = '0;
      tail_nxt    = '0;
      decided_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_chan.payload.data_byte;
      s1_last_r <= in_chan.payload.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WINDOW_RESET;
    end else if (cfg_chan.valid) begin
      win_r <= cfg_chan.payload.window_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MAGIC;
      pos_r     <= '0;
      btype_r   <= '0;
      size_r    <= '0;
      skip_r    <= '0;
      blocks_r  <= '0;
      tail_r    <= '0;
      decided_r <= 1'b0;
    end else if (s1_go) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      btype_r   <= btype_nxt;
      size_r    <= size_nxt;
      skip_r    <= skip_nxt;
      blocks_r  <= blocks_nxt;
      tail_r    <= tail_nxt;
      decided_r <= decided_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && fin) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && fin) begin
      out_pl_r.accepted    <= fin_ok;
      out_pl_r.file_length <= fin_ok ? fin_len : 32'd0;
    end
  end

endmodule

>>> rtl/core/vcls_checker.sv
`timescale 1ns / 1ps
`include "voc_container_length_scanner_unit_assert.svh"

module vcls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic [31:0] out_length
);

  `VCLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_accepted) && $stable(out_length))
  `VCLS_ASSERT_SAME(a_reject_zero_len, out_valid && !out_accepted, out_length == 32'd0)
  `VCLS_ASSERT_SAME(a_result_has_source, $rose(out_valid), $past(in_valid && in_ready, 2))
  `VCLS_ASSERT_RESET(a_reset_clears_out, !rst_n, !out_valid)

endmodule

bind voc_container_length_scanner_unit vcls_checker u_vcls_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_accepted (out_chan.payload.accepted),
  .out_length   (out_chan.payload.file_length)
);

>>> dv/tb_voc_container_length_scanner_unit.sv
`timescale 1ns / 1ps

module tb_voc_container_length_scanner_unit;
  import vcls_pkg::*;

  localparam int MAX_BLOCKS         = 2000000;
  localparam int TAIL_LIMIT         = 16;
  localparam int FIRST_BLOCK_OFFSET = 26;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;
  localparam int PAYLOAD_CAP  = 40;
  localparam int NO_END       = -1;
  localparam int TERM_LOW     = int'(BLK_TYPE_MAX) + 1;
  localparam int N_DIR        = 20;
  localparam int CHUNK_BYTES  = 30;
  localparam int CHUNK_CANDS  = 1;
  localparam int HOLD_CANDS   = 4;

  localparam logic [7:0] VOC_SIG [20] = '{
    8'h43, 8'h72, 8'h65, 8'h61, 8'h74, 8'h69, 8'h76, 8'h65, 8'h20, 8'h56,
    8'h6F, 8'h69, 8'h63, 8'h65, 8'h20, 8'h46, 8'h69, 8'h6C, 8'h65, 8'h1A
  };

  localparam out_payload_t REJECT = '{accepted: 1'b0, file_length: 32'd0};

  typedef enum logic [2:0] {SC_MAGIC, SC_GAP, SC_HEADER, SC_PAYLOAD, SC_TAIL} scan_phase_t;

  typedef struct {
    logic [31:0]  win;
    int           bad;
    logic [7:0]   typ;
    logic [23:0]  sz;
    logic [7:0]   b4;
    int           term;
    int           ntail;
    int           cut;
    bit           typed;
    out_payload_t res;
  } scan_vec_t;

  logic clk;
  logic rst_n;

  vcls_stream_if #(.payload_t(in_payload_t))  in_if ();
  vcls_stream_if #(.payload_t(out_payload_t)) out_if ();
  vcls_stream_if #(.payload_t(cfg_payload_t)) cfg_if ();

  voc_container_length_scanner_unit #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .TAIL_LIMIT(TAIL_LIMIT),
    .FIRST_BLOCK_OFFSET(FIRST_BLOCK_OFFSET)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // scanner shadow state
  logic [31:0]  win_len;
  scan_phase_t  sc_ph;
  logic [31:0]  sc_pos;
  logic [7:0]   sc_type;
  logic [23:0]  sc_size;
  logic [23:0]  sc_skip;
  logic [20:0]  sc_blocks;
  logic [4:0]   sc_tail;
  bit           sc_done;
  out_payload_t sc_res;

  out_payload_t verdict_q[$];
  logic [7:0]   cand[$];
  scan_vec_t    dir_tab[N_DIR];
  logic [31:0]  win_plan[9];

  int           err_cnt;
  int           cycle_cnt;
  int           byte_total;
  int           cand_total;
  int           src_idle;
  int           snk_idle;
  bit           hold_req;
  bit           hold_done;
  int           hold_left;
  bit           typed_on;
  out_payload_t typed_res;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void scan_clear();
    sc_ph     = SC_MAGIC;
    sc_pos    = '0;
    sc_type   = '0;
    sc_size   = '0;
    sc_skip   = '0;
    sc_blocks = '0;
    sc_tail   = '0;
    sc_done   = 1'b0;
  endfunction

  function automatic void scan_close(input bit ok, input longint unsigned len);
    sc_done            = 1'b1;
    sc_res.accepted    = ok;
    sc_res.file_length = ok ? len[31:0] : 32'd0;
  endfunction

  function automatic void tail_step(input longint unsigned p, input logic [7:0] x);
    if (x == 8'd0) begin
      scan_close(1'b1, p);
      return;
    end
    sc_tail = sc_tail + 5'd1;
    if (sc_tail >= TAIL_LIMIT || p + 1 >= win_len)
      scan_close(1'b1, p + 1);
  endfunction

  function automatic void tail_begin(input longint unsigned term_pos);
    sc_tail = '0;
    if (TAIL_LIMIT == 0 || term_pos >= win_len)
      scan_close(1'b1, term_pos);
    else
      sc_ph = SC_TAIL;
  endfunction

  function automatic void header_step(input longint unsigned p, input logic [7:0] x);
    logic [23:0] idx;
    idx = sc_skip;
    if (idx == 0) begin
      if (p + HDR_LEN > win_len || sc_blocks >= MAX_BLOCKS) begin
        scan_close(1'b0, 0);
        return;
      end
      sc_type = x;
      sc_size = '0;
      if (x == BLK_TYPE_END || x > BLK_TYPE_MAX) begin
        if (sc_blocks == 0) begin
          scan_close(1'b0, 0);
          return;
        end
        if (x > BLK_TYPE_MAX) begin
          tail_begin(p);
          if (!sc_done)
            tail_step(p, x);
          return;
        end
      end
      sc_skip = 24'd1;
      return;
    end
    if (sc_type != BLK_TYPE_END &&
        (idx < 3 || sc_type == BLK_TYPE_EXT1 || sc_type == BLK_TYPE_EXT2))
      sc_size = sc_size | (24'(x) << (8 * (idx - 1)));
    if (idx < 3) begin
      sc_skip = idx + 24'd1;
      return;
    end
    sc_skip = '0;
    if (sc_type == BLK_TYPE_END) begin
      tail_begin(p + 1);
      return;
    end
    if (sc_size == 0 || p + 1 + sc_size > win_len) begin
      scan_close(1'b0, 0);
      return;
    end
    sc_skip   = sc_size;
    sc_ph     = SC_PAYLOAD;
    sc_blocks = sc_blocks + 21'd1;
  endfunction

  function automatic void scan_byte(input logic [7:0] x, input logic lst,
                                    output bit got, output out_payload_t r);
    longint unsigned p;
    bit was;
    p   = sc_pos;
    was = sc_done;
    if (!sc_done) begin
      case (sc_ph)
        SC_MAGIC: begin
          if (p >= MAGIC_LEN || VOC_SIG[p] != x)
            scan_close(1'b0, 0);
          else if (p == MAGIC_LEN - 1)
            sc_ph = (FIRST_BLOCK_OFFSET > MAGIC_LEN) ? SC_GAP : SC_HEADER;
        end
        SC_GAP: begin
          if (p + 1 >= FIRST_BLOCK_OFFSET) begin
            sc_ph   = SC_HEADER;
            sc_skip = '0;
          end
        end
        SC_HEADER: header_step(p, x);
        SC_PAYLOAD: begin
          if (sc_skip > 0)
            sc_skip = sc_skip - 24'd1;
          if (sc_skip == 0) begin
            sc_ph   = SC_HEADER;
            sc_size = '0;
          end
        end
        SC_TAIL: tail_step(p, x);
        default: scan_close(1'b0, 0);
      endcase
    end
    if (lst && !sc_done) begin
      if (sc_ph == SC_TAIL)
        scan_close(1'b1, p + 1);
      else if (sc_ph == SC_HEADER && sc_type == BLK_TYPE_END && sc_skip != 0)
        scan_close(1'b1, p + 1 - sc_skip + HDR_LEN);
      else
        scan_close(1'b0, 0);
    end
    got = sc_done && !was;
    r   = sc_res;
    if (sc_pos != 32'hFFFF_FFFF)
      sc_pos = sc_pos + 32'd1;
    if (lst)
      scan_clear();
  endfunction

  // candidate builders
  function automatic void add_byte(input logic [7:0] b);
    cand = {cand, b};
  endfunction

  task automatic add_sig(input int bad);
    logic [7:0] b;
    for (int i = 0; i < MAGIC_LEN; i++) begin
      b = VOC_SIG[i];
      if (i == bad)
        b = b ^ (8'h01 << $urandom_range(7));
      add_byte(b);
    end
    for (int i = MAGIC_LEN; i < FIRST_BLOCK_OFFSET; i++)
      add_byte(8'($urandom));
  endtask

  task automatic add_block(input logic [7:0] typ, input logic [23:0] sz, input logic [7:0] b4);
    add_byte(typ);
    add_byte(sz[7:0]);
    add_byte(sz[15:8]);
    add_byte((typ == BLK_TYPE_EXT1 || typ == BLK_TYPE_EXT2) ? sz[23:16] : b4);
    for (int i = 0; i < sz && i < PAYLOAD_CAP; i++)
      add_byte(8'($urandom));
  endtask

  task automatic add_end(input int term, input int ntail);
    if (term == NO_END)
      return;
    if (term == int'(BLK_TYPE_END)) begin
      add_byte(BLK_TYPE_END);
      repeat (3) add_byte(8'($urandom));
    end else begin
      add_byte(8'(term));
    end
    repeat (ntail) add_byte(8'($urandom_range(1, 255)));
    add_byte(8'h00);
    repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
  endtask

  task automatic push_byte(input logic [7:0] b, input logic lst);
    bit got;
    out_payload_t r;
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{data_byte: b, last_byte: lst};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    scan_byte(b, lst, got, r);
    if (got) begin
      if (typed_on) begin
        verdict_q = {verdict_q, typed_res};
        typed_on = 1'b0;
      end else begin
        verdict_q = {verdict_q, r};
      end
    end
    @(negedge clk);
  endtask

  task automatic send_cand(input int cut, input bit typed, input out_payload_t res);
    int n;
    if (cut > 0)
      while (cand.size() > cut) void'(cand.pop_back());
    typed_on  = typed;
    typed_res = res;
    n = cand.size();
    for (int i = 0; i < n; i++)
      push_byte(cand[i], i == n - 1);
    byte_total += n;
    cand_total++;
    cand.delete();
  endtask

  task automatic rand_cand();
    int q;
    int nb;
    int term;
    logic [7:0] typ;
    logic [23:0] sz;
    q = $urandom_range(99);
    if (q < 10) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
      send_cand(0, 1'b0, REJECT);
      return;
    end
    add_sig(($urandom_range(99) < 8) ? int'($urandom_range(0, MAGIC_LEN - 1)) : -1);
    nb = $urandom_range(1, 3);
    repeat (nb) begin
      q = $urandom_range(99);
      if (q < 10)      typ = BLK_TYPE_EXT1;
      else if (q < 20) typ = BLK_TYPE_EXT2;
      else if (q < 85) typ = 8'($urandom_range(1, int'(BLK_TYPE_MAX)));
      else if (q < 92) typ = BLK_TYPE_END;
      else             typ = 8'($urandom_range(TERM_LOW, 255));
      q = $urandom_range(99);
      if (q < 5)       sz = '0;
      else if (q < 10) sz = 24'($urandom);
      else             sz = 24'($urandom_range(1, 12));
      add_block(typ, sz, 8'($urandom));
    end
    q = $urandom_range(99);
    if (q < 45)      term = int'(BLK_TYPE_END);
    else if (q < 85) term = $urandom_range(TERM_LOW, 255);
    else             term = NO_END;
    add_end(term, $urandom_range(0, 20));
    send_cand(($urandom_range(99) < 15) ? int'($urandom_range(1, cand.size())) : 0,
              1'b0, REJECT);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_window(input logic [31:0] val);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{window_length: val};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    win_len = val;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // result sink
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
      if (hold_left == 0)
        hold_done = 1'b1;
    end else if (hold_req && !hold_done) begin
      out_if.ready <= 1'b0;
      hold_left = LONG_HOLD;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    out_payload_t e;
    out_payload_t a;
    if (rst_n && out_if.valid && out_if.ready) begin
      a = out_if.payload;
      if (verdict_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected transaction: expected none, actual accepted=%0b length=%0d",
                 $time, a.accepted, a.file_length);
      end else begin
        e = verdict_q.pop_front();
        if (e.accepted !== a.accepted) begin
          err_cnt++;
          $display("%0t: accepted mismatch: expected %0b, actual %0b",
                   $time, e.accepted, a.accepted);
        end
        if (e.file_length !== a.file_length) begin
          err_cnt++;
          $display("%0t: file_length mismatch: expected %0d, actual %0d",
                   $time, e.file_length, a.file_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int chunk_bytes;
    int chunk_cands;
    int need_cands;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    out_if.ready   = 1'b0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    byte_total     = 0;
    cand_total     = 0;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    hold_left      = 0;
    typed_on       = 1'b0;
    typed_res      = REJECT;
    src_idle       = 30;
    snk_idle       = 75;
    win_len        = WINDOW_RESET;
    sc_res         = REJECT;
    scan_clear();

    //         window        bad  type           size        b4     end            tail cut typed res
    dir_tab = '{
      '{WINDOW_RESET,  0,  8'd1,          24'd1,      8'h00, int'(BLK_TYPE_END), 0,  1, 1'b1, REJECT},
      '{WINDOW_RESET,  19, 8'd1,          24'd1,      8'h00, int'(BLK_TYPE_END), 0,  0, 1'b1, REJECT},
      '{WINDOW_RESET,  -1, 8'd1,          24'd1,      8'hFF, int'(BLK_TYPE_END), 0,  0, 1'b0, '0},
      '{WINDOW_RESET,  -1, BLK_TYPE_END,  24'd0,      8'h00, NO_END,             0,  0, 1'b1, REJECT},
      '{WINDOW_RESET,  -1, 8'hFF,         24'd0,      8'h00, NO_END,             0,  0, 1'b1, REJECT},
      '{WINDOW_RESET,  -1, 8'd1,          24'd0,      8'h00, int'(BLK_TYPE_END), 0,  0, 1'b1, REJECT},
      '{WINDOW_RESET,  -1, BLK_TYPE_EXT2, 24'd3,      8'h00, 255,                2,  0, 1'b0, '0},
      '{WINDOW_RESET,  -1, BLK_TYPE_MAX,  24'd5,      8'h00, TERM_LOW,           20, 0, 1'b0, '0},
      '{WINDOW_RESET,  -1, 8'd1,          24'd1,      8'h00, int'(BLK_TYPE_END), 0,  33, 1'b0, '0},
      '{WINDOW_RESET,  -1, 8'd2,          24'd2,      8'h00, TERM_LOW,           5,  35, 1'b0, '0},
      '{WINDOW_RESET,  -1, 8'd3,          24'd6,      8'h00, int'(BLK_TYPE_END), 0,  31, 1'b1, REJECT},
      '{WINDOW_RESET,  -1, 8'd4,          24'd1,      8'h00, NO_END,             0,  31, 1'b1, REJECT},
      '{32'd0,         -1, 8'd1,          24'd1,      8'h00, int'(BLK_TYPE_END), 0,  0, 1'b1, REJECT},
      '{32'hFFFF_FFFF, -1, BLK_TYPE_EXT1, 24'd4,      8'h00, int'(BLK_TYPE_END), 3,  0, 1'b0, '0},
      '{32'd30,        -1, 8'd1,          24'd1,      8'h00, int'(BLK_TYPE_END), 0,  0, 1'b1, REJECT},
      '{32'd35,        -1, 8'd1,          24'd1,      8'h00, int'(BLK_TYPE_END), 3,  0, 1'b0, '0},
      '{32'd40,        -1, BLK_TYPE_EXT1, 24'h010001, 8'h00, int'(BLK_TYPE_END), 0,  0, 1'b1, REJECT},
      '{32'd40,        -1, 8'd5,          24'd1,      8'h01, int'(BLK_TYPE_END), 0,  0, 1'b0, '0},
      '{32'd40,        -1, 8'd1,          24'd1,      8'h00, int'(BLK_TYPE_END), 0,  1, 1'b1, REJECT},
      '{WINDOW_RESET,  -1, 8'd7,          24'd3,      8'hA5, int'(BLK_TYPE_END), 1,  0, 1'b0, '0}
    };
    win_plan = '{32'hFFFF_FFFF, 32'd45, 32'd120, 32'd0, 32'd36, 32'd70, 32'd0, 32'd1000,
                 WINDOW_RESET};
    win_plan[3] = $urandom;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].win != win_len) begin
        wait_idle();
        write_window(dir_tab[k].win);
      end
      add_sig(dir_tab[k].bad);
      add_block(dir_tab[k].typ, dir_tab[k].sz, dir_tab[k].b4);
      add_end(dir_tab[k].term, dir_tab[k].ntail);
      send_cand(dir_tab[k].cut, dir_tab[k].typed, dir_tab[k].res);
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 30 : (ph == 1) ? 75 : 0;
      snk_idle = (ph == 0) ? 75 : (ph == 1) ? 30 : 0;
      for (int ch = 0; ch < 3; ch++) begin
        wait_idle();
        write_window(win_plan[ph * 3 + ch]);
        if (ph == 2 && ch == 0)
          hold_req = 1'b1;
        need_cands  = (ph == 2 && ch == 0) ? HOLD_CANDS : CHUNK_CANDS;
        chunk_bytes = byte_total;
        chunk_cands = cand_total;
        while (byte_total - chunk_bytes < CHUNK_BYTES || cand_total - chunk_cands < need_cands)
          rand_cand();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (verdict_q.size() != 0) begin
      err_cnt += verdict_q.size();
      $display("%0t: %0d transactions missing: expected accepted=%0b length=%0d, actual none",
               $time, verdict_q.size(), verdict_q[0].accepted, verdict_q[0].file_length);
    end
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
